@@ rtl/core/ntt_radix8_butterfly_unit_macros.svh @@
// assertion macros for the radix-8 transform butterfly
`ifndef NTT_RADIX8_BUTTERFLY_UNIT_MACROS_SVH
`define NTT_RADIX8_BUTTERFLY_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NTT8_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("ntt8 assertion failed");
`define NTT8_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("ntt8 assertion failed");
`else
`define NTT8_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons)
`define NTT8_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)
`endif
`endif

@@ rtl/core/ntt8_pkg.sv @@
// shared constants, types and modular arithmetic helpers for the ntt butterfly
package ntt8_pkg;

    localparam int MOD_BITS  = 62;
    localparam int FIELD_W   = 62;
    localparam int NPTS      = 8;
    localparam int NROOT     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = $clog2(MOD_BITS);

    localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(64'd2013265921);

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_THREE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_FIVE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_SIX   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_SEVEN = CFG_IDX_W'(4);

    typedef logic [MOD_BITS-1:0] res_t;

    // a, b below m
    function automatic res_t mod_add(res_t a, res_t b, res_t m);
        logic [MOD_BITS:0] s;
        logic [MOD_BITS:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, m};
        return (s >= {1'b0, m}) ? t[MOD_BITS-1:0] : s[MOD_BITS-1:0];
    endfunction

    function automatic res_t mod_sub(res_t a, res_t b, res_t m);
        logic [MOD_BITS:0] d;
        logic [MOD_BITS:0] e;
        d = {1'b0, a} - {1'b0, b};
        e = d + {1'b0, m};
        return (a >= b) ? d[MOD_BITS-1:0] : e[MOD_BITS-1:0];
    endfunction

    // one restoring remainder step: (2r + bt) mod m
    function automatic res_t red_step(res_t r, logic bt, res_t m);
        logic [MOD_BITS:0] t;
        logic [MOD_BITS:0] u;
        t = {r, bt};
        u = t - {1'b0, m};
        return (t >= {1'b0, m}) ? u[MOD_BITS-1:0] : t[MOD_BITS-1:0];
    endfunction

    // one double-and-add step of a modular product
    function automatic res_t mul_step(res_t r, res_t a, logic bt, res_t m);
        res_t d;
        d = red_step(r, 1'b0, m);
        return bt ? mod_add(d, a, m) : d;
    endfunction

endpackage

@@ rtl/core/ntt_radix8_butterfly_unit.sv @@
// radix-8 number theoretic transform butterfly, deep pipeline
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  input   | in_valid, in_ready, in_0..in_7    | in
//  output  | out_valid, out_ready, out_0..out_7| out
//  config  | cfg_valid, cfg_ready, cfg_index,  | in
//          | cfg_data                          |
//
// one word per cycle unless the output or a config reduction stalls it; a
// bit-per-stage remainder pipeline for the inputs, then a bit-per-stage modular
// multiplier; a config write to a root or modulus register starts a reduction
// of the root constants, during which no word is accepted
// reset clears valid bits and root constants and loads the default modulus; the
// whole pipeline holds while the output word waits, and in_ready drops with it
`include "ntt_radix8_butterfly_unit_macros.svh"
module ntt_radix8_butterfly_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_0,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_1,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_2,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_3,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_4,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_5,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_6,
    input  logic [ntt8_pkg::FIELD_W-1:0]      in_7,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_0,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_1,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_2,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_3,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_4,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_5,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_6,
    output logic [ntt8_pkg::FIELD_W-1:0]      out_7,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ntt8_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ntt8_pkg::FIELD_W-1:0]      cfg_data
);
    import ntt8_pkg::*;

    localparam int NSTG  = 2 * MOD_BITS + 4;

    // configuration
    res_t             modulus_reg, modulus_next;
    res_t             raw_reg [NROOT];
    res_t             raw_next [NROOT];
    res_t             c_red_reg [NROOT];
    res_t             c_red_next [NROOT];
    logic             cfg_busy_reg, cfg_busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] bit_idx;

    // pipeline control
    logic [NSTG-1:0]  vld_reg, vld_next;
    logic             advance;

    // pipeline data
    res_t in_w [NPTS];
    res_t rr_reg [MOD_BITS][NPTS];
    res_t rr_next [MOD_BITS][NPTS];
    res_t rx_reg [MOD_BITS][NPTS];
    res_t rx_next [MOD_BITS][NPTS];
    res_t a_reg [NROOT];
    res_t a_next [NROOT];
    res_t b_reg [NROOT];
    res_t b_next [NROOT];
    res_t pp_reg [NROOT];
    res_t pp_next [NROOT];
    res_t md_reg [NROOT];
    res_t md_next [NROOT];
    res_t mr_reg [MOD_BITS][NROOT];
    res_t mr_next [MOD_BITS][NROOT];
    res_t mm_reg [MOD_BITS][NROOT];
    res_t mm_next [MOD_BITS][NROOT];
    res_t mp_reg [MOD_BITS][NROOT];
    res_t mp_next [MOD_BITS][NROOT];
    res_t q_reg [NROOT];
    res_t q_next [NROOT];
    res_t pc_reg [NROOT];
    res_t pc_next [NROOT];
    res_t out_reg [NPTS];
    res_t out_next [NPTS];

    assign cfg_ready = 1'b1;
    assign bit_idx   = CNT_W'(MOD_BITS - 1) - cnt_reg;

    always_comb
    begin
        modulus_next  = modulus_reg;
        raw_next      = raw_reg;
        c_red_next    = c_red_reg;
        cfg_busy_next = cfg_busy_reg;
        cnt_next      = cnt_reg;
        if (cfg_busy_reg)
        begin
            for (int j = 0; j < NROOT; j++)
            begin
                c_red_next[j] = red_step(c_red_reg[j], raw_reg[j][bit_idx], modulus_reg);
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MOD_BITS - 1))
            begin
                cfg_busy_next = 1'b0;
            end
        end
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODULUS:    modulus_next = cfg_data[MOD_BITS-1:0];
                REG_ROOT_THREE: raw_next[0]  = cfg_data[MOD_BITS-1:0];
                REG_ROOT_FIVE:  raw_next[1]  = cfg_data[MOD_BITS-1:0];
                REG_ROOT_SIX:   raw_next[2]  = cfg_data[MOD_BITS-1:0];
                REG_ROOT_SEVEN: raw_next[3]  = cfg_data[MOD_BITS-1:0];
                default:        ;
            endcase
            // any real write restarts the constant reduction
            if (cfg_index <= REG_ROOT_SEVEN)
            begin
                cfg_busy_next = 1'b1;
                cnt_next      = '0;
                for (int j = 0; j < NROOT; j++)
                begin
                    c_red_next[j] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET[MOD_BITS-1:0];
            cfg_busy_reg <= 1'b0;
            cnt_reg      <= '0;
            vld_reg      <= '0;
            for (int j = 0; j < NROOT; j++)
            begin
                raw_reg[j]   <= '0;
                c_red_reg[j] <= '0;
            end
        end
        else
        begin
            modulus_reg  <= modulus_next;
            raw_reg      <= raw_next;
            c_red_reg    <= c_red_next;
            cfg_busy_reg <= cfg_busy_next;
            cnt_reg      <= cnt_next;
            vld_reg      <= vld_next;
        end
    end

    assign advance   = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = advance && !cfg_busy_reg;
    assign out_valid = vld_reg[NSTG-1];
    assign vld_next  = advance ? {vld_reg[NSTG-2:0], in_valid && in_ready} : vld_reg;

    assign in_w[0] = in_0[MOD_BITS-1:0];
    assign in_w[1] = in_1[MOD_BITS-1:0];
    assign in_w[2] = in_2[MOD_BITS-1:0];
    assign in_w[3] = in_3[MOD_BITS-1:0];
    assign in_w[4] = in_4[MOD_BITS-1:0];
    assign in_w[5] = in_5[MOD_BITS-1:0];
    assign in_w[6] = in_6[MOD_BITS-1:0];
    assign in_w[7] = in_7[MOD_BITS-1:0];

    // input remainder: one bit per stage, msb first
    for (genvar gs = 0; gs < MOD_BITS; gs++)
    begin : g_red
        for (genvar gk = 0; gk < NPTS; gk++)
        begin : g_lane
            if (gs == 0)
            begin : g_first
                assign rr_next[gs][gk] = red_step('0, in_w[gk][MOD_BITS-1], modulus_reg);
                assign rx_next[gs][gk] = in_w[gk];
            end
            else
            begin : g_rest
                assign rr_next[gs][gk] = red_step(rr_reg[gs-1][gk],
                                                  rx_reg[gs-1][gk][MOD_BITS-1-gs],
                                                  modulus_reg);
                assign rx_next[gs][gk] = rx_reg[gs-1][gk];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NROOT; k++)
        begin
            a_next[k] = mod_add(rr_reg[MOD_BITS-1][k], rr_reg[MOD_BITS-1][k+4], modulus_reg);
            b_next[k] = mod_sub(rr_reg[MOD_BITS-1][k], rr_reg[MOD_BITS-1][k+4], modulus_reg);
        end
    end

    // pass-through terms p0 p1 p2 p4, and multiplicands for p3 p5 p6 p7
    always_comb
    begin
        pp_next[0] = mod_add(a_reg[0], a_reg[2], modulus_reg);
        pp_next[1] = mod_sub(a_reg[0], a_reg[2], modulus_reg);
        pp_next[2] = mod_add(a_reg[1], a_reg[3], modulus_reg);
        pp_next[3] = b_reg[0];
        md_next[0] = mod_sub(a_reg[1], a_reg[3], modulus_reg);
        md_next[1] = b_reg[2];
        md_next[2] = mod_sub(b_reg[1], b_reg[3], modulus_reg);
        md_next[3] = mod_add(b_reg[1], b_reg[3], modulus_reg);
    end

    // modular products: one constant bit per stage, msb first
    for (genvar gs = 0; gs < MOD_BITS; gs++)
    begin : g_mul
        for (genvar gj = 0; gj < NROOT; gj++)
        begin : g_lane
            if (gs == 0)
            begin : g_first
                assign mr_next[gs][gj] = mul_step('0, md_reg[gj],
                                                  c_red_reg[gj][MOD_BITS-1], modulus_reg);
                assign mm_next[gs][gj] = md_reg[gj];
                assign mp_next[gs][gj] = pp_reg[gj];
            end
            else
            begin : g_rest
                assign mr_next[gs][gj] = mul_step(mr_reg[gs-1][gj], mm_reg[gs-1][gj],
                                                  c_red_reg[gj][MOD_BITS-1-gs], modulus_reg);
                assign mm_next[gs][gj] = mm_reg[gs-1][gj];
                assign mp_next[gs][gj] = mp_reg[gs-1][gj];
            end
        end
    end

    always_comb
    begin
        q_next[0]  = mod_add(mp_reg[MOD_BITS-1][3], mr_reg[MOD_BITS-1][1], modulus_reg);
        q_next[1]  = mod_sub(mp_reg[MOD_BITS-1][3], mr_reg[MOD_BITS-1][1], modulus_reg);
        q_next[2]  = mod_add(mr_reg[MOD_BITS-1][2], mr_reg[MOD_BITS-1][3], modulus_reg);
        q_next[3]  = mod_sub(mr_reg[MOD_BITS-1][2], mr_reg[MOD_BITS-1][3], modulus_reg);
        pc_next[0] = mp_reg[MOD_BITS-1][0];
        pc_next[1] = mp_reg[MOD_BITS-1][1];
        pc_next[2] = mp_reg[MOD_BITS-1][2];
        pc_next[3] = mr_reg[MOD_BITS-1][0];
    end

    always_comb
    begin
        out_next[0] = mod_add(pc_reg[0], pc_reg[2], modulus_reg);
        out_next[1] = mod_add(q_reg[0], q_reg[2], modulus_reg);
        out_next[2] = mod_add(pc_reg[1], pc_reg[3], modulus_reg);
        out_next[3] = mod_sub(q_reg[1], q_reg[3], modulus_reg);
        out_next[4] = mod_sub(pc_reg[0], pc_reg[2], modulus_reg);
        out_next[5] = mod_sub(q_reg[0], q_reg[2], modulus_reg);
        out_next[6] = mod_sub(pc_reg[1], pc_reg[3], modulus_reg);
        out_next[7] = mod_add(q_reg[1], q_reg[3], modulus_reg);
        // zero modulus gives an all-zero word
        if (modulus_reg == '0)
        begin
            for (int k = 0; k < NPTS; k++)
            begin
                out_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rr_reg  <= rr_next;
            rx_reg  <= rx_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            pp_reg  <= pp_next;
            md_reg  <= md_next;
            mr_reg  <= mr_next;
            mm_reg  <= mm_next;
            mp_reg  <= mp_next;
            q_reg   <= q_next;
            pc_reg  <= pc_next;
            out_reg <= out_next;
        end
    end

    assign out_0 = FIELD_W'(out_reg[0]);
    assign out_1 = FIELD_W'(out_reg[1]);
    assign out_2 = FIELD_W'(out_reg[2]);
    assign out_3 = FIELD_W'(out_reg[3]);
    assign out_4 = FIELD_W'(out_reg[4]);
    assign out_5 = FIELD_W'(out_reg[5]);
    assign out_6 = FIELD_W'(out_reg[6]);
    assign out_7 = FIELD_W'(out_reg[7]);

    `NTT8_ASSERT_NEXT(a_stall_hold, clk, rst_n, !advance, vld_reg == $past(vld_reg))
    `NTT8_ASSERT_NEXT(a_write_busy, clk, rst_n,
        cfg_valid && cfg_index <= REG_ROOT_SEVEN, cfg_busy_reg)
    `NTT8_ASSERT_IMPLY(a_const_reduced, clk, rst_n, !cfg_busy_reg && modulus_reg != '0,
        c_red_reg[0] < modulus_reg && c_red_reg[1] < modulus_reg &&
        c_red_reg[2] < modulus_reg && c_red_reg[3] < modulus_reg)
    `NTT8_ASSERT_IMPLY(a_out_reduced, clk, rst_n, out_valid && modulus_reg != '0,
        out_reg[0] < modulus_reg && out_reg[1] < modulus_reg &&
        out_reg[2] < modulus_reg && out_reg[3] < modulus_reg &&
        out_reg[4] < modulus_reg && out_reg[5] < modulus_reg &&
        out_reg[6] < modulus_reg && out_reg[7] < modulus_reg)

endmodule
